// ===== sv/kst_pkg.sv =====
package kst_pkg;

  // input op codes
  localparam logic [1:0] OP_SCAN  = 2'd0;
  localparam logic [1:0] OP_IDLE  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_ACTION = 2'd2;

  // window action codes
  localparam logic [1:0] ACT_TAB    = 2'd0;
  localparam logic [1:0] ACT_BREAK  = 2'd1;
  localparam logic [1:0] ACT_NEWCON = 2'd2;
  localparam logic [1:0] ACT_RAISE  = 2'd3;

  // scan codes and keyboard bytes
  localparam logic [7:0] SC_TAB         = 8'h0f;
  localparam logic [7:0] SC_F1          = 8'h3b;
  localparam logic [7:0] SC_F2          = 8'h3c;
  localparam logic [7:0] SC_F11         = 8'h57;
  localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2a;
  localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK  = 8'haa;
  localparam logic [7:0] SC_RSHIFT_BRK  = 8'hb6;
  localparam logic [7:0] SC_CAPS        = 8'h3a;
  localparam logic [7:0] SC_NUM         = 8'h45;
  localparam logic [7:0] SC_SCROLL      = 8'h46;
  localparam logic [7:0] SC_ACK         = 8'hfa;
  localparam logic [7:0] SC_RESEND      = 8'hfe;
  localparam logic [7:0] LED_CMD        = 8'hed;
  localparam logic [7:0] CASE_FLIP      = 8'h20;

  // lock bit positions
  localparam int unsigned LOCK_CAPS   = 2;
  localparam int unsigned LOCK_NUM    = 1;
  localparam int unsigned LOCK_SCROLL = 0;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] scancode;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] initial_leds;
  } cfg_item_t;

  // one queue record: LED_CMD, then the lock bits if has_lock
  typedef struct packed {
    logic       has_lock;
    logic [2:0] lock;
  } q_rec_t;

  typedef struct packed {
    logic       clear;
    logic       pop;
    logic       push;
    logic [2:0] lock;
  } q_cmd_t;

  typedef struct packed {
    logic       nonempty;
    logic [7:0] head_byte;
  } q_stat_t;

  localparam logic [7:0] TBL_PLAIN [128] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h40, 8'h5b, 8'h0a, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
    8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00
  };

  localparam logic [7:0] TBL_SHIFT [128] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h7e, 8'h3d, 8'h7e, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h60, 8'h7b, 8'h0a, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
    8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00, 8'h00
  };

endpackage

// ===== sv/kst_stream_if.sv =====
interface kst_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/kst_cmd_queue.sv =====
// Keyboard command queue. Bytes are held as records in a registered-read
// memory; the head record is prefetched every cycle with write forwarding.
module kst_cmd_queue import kst_pkg::*; #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_cmd_t  cmd_i,
  output q_stat_t stat_o
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] PAIR_MAX  = CW'(QUEUE_DEPTH - 2);

  q_rec_t        mem_q [QUEUE_DEPTH];
  q_rec_t        rd_q;
  q_rec_t        wrec_q;
  logic          fwd_q;

  logic [AW-1:0] head_q, head_d, tail_q, tail_d, head_base, tail_base;
  logic [CW-1:0] bytes_q, bytes_d, bytes_base;
  logic          half_q, half_d;
  q_rec_t        head_rec, wrec;
  logic          we;

  assign head_rec = fwd_q ? wrec_q : rd_q;

  assign stat_o.nonempty  = bytes_q != '0;
  assign stat_o.head_byte = half_q ? {5'b0, head_rec.lock} : LED_CMD;

  always_comb begin
    head_base  = head_q;
    tail_base  = tail_q;
    bytes_base = bytes_q;
    half_d     = half_q;
    if (cmd_i.clear) begin
      head_base  = '0;
      tail_base  = '0;
      bytes_base = '0;
      half_d     = 1'b0;
    end else if (cmd_i.pop) begin
      bytes_base = bytes_q - CW'(1);
      // the record is done once its last byte leaves
      if (half_q || !head_rec.has_lock) begin
        head_base = (head_q == LAST_ADDR) ? '0 : head_q + AW'(1);
        half_d    = 1'b0;
      end else begin
        half_d = 1'b1;
      end
    end
    head_d = head_base;

    // bytes that do not fit are dropped
    we            = cmd_i.push && (bytes_base < FULL_CNT);
    wrec.has_lock = bytes_base <= PAIR_MAX;
    wrec.lock     = cmd_i.lock;
    tail_d        = tail_base;
    bytes_d       = bytes_base;
    if (we) begin
      tail_d  = (tail_base == LAST_ADDR) ? '0 : tail_base + AW'(1);
      bytes_d = bytes_base + (wrec.has_lock ? CW'(2) : CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      bytes_q <= '0;
      half_q  <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      bytes_q <= bytes_d;
      half_q  <= half_d;
      fwd_q   <= we && (tail_base == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[tail_base] <= wrec;
    end
    rd_q   <= mem_q[head_d];
    wrec_q <= wrec;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_q <= FULL_CNT)
    else $error("queue byte count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> bytes_q != '0)
    else $error("pop from empty queue");

  a_clear_loads_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear && cmd_i.push |=> bytes_q == CW'(2) && !half_q)
    else $error("start did not leave one LED pair");

endmodule

// ===== sv/kst_out_fifo.sv =====
// Four-entry result buffer; takes up to two results a cycle while two entries are free, gives one when ready_i is high.
module kst_out_fifo import kst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [1:0] wr_cnt_i,
  input  out_item_t wr0_i,
  input  out_item_t wr1_i,
  output logic      space_o,
  output logic      valid_o,
  output out_item_t data_o,
  input  logic      ready_i
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  out_item_t     buf_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          rd_fire;

  assign valid_o = count_q != '0;
  assign data_o  = buf_q[rd_ptr_q];
  assign space_o = count_q <= CW'(DEPTH - 2);
  assign rd_fire = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PW'(wr_cnt_i);
      rd_ptr_q <= rd_ptr_q + PW'(rd_fire);
      count_q  <= count_q + CW'(wr_cnt_i) - CW'(rd_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      buf_q[wr_ptr_q] <= wr0_i;
    end
    if (wr_cnt_i == 2'd2) begin
      buf_q[wr_ptr_q + PW'(1)] <= wr1_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("result buffer overflow");

  a_write_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_cnt_i != 2'd0 |-> count_q <= CW'(DEPTH - 2))
    else $error("results written without room");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_cnt_i == 2'd0 && !rd_fire |=> $stable(count_q))
    else $error("count moved without a transfer");

endmodule

// ===== sv/keyboard_scancode_translator_core.sv =====
// Channel | Dir | Payload                         | Transfer
// cfg_i   | in  | initial_leds[2:0]               | valid & ready (ready always high)
// in_i    | in  | op[1:0], scancode[7:0]          | valid & ready
// out_o   | out | kind[1:0], value[7:0], last     | valid & ready
//
// One item is taken per cycle while ready is high; its results (zero to two) land in a
// four-entry result buffer the same edge and leave one per cycle while out_o is ready,
// so ready drops only when fewer than two slots are free. A steady stream of items
// giving two results cannot be taken one per cycle. The command queue head is prefetched
// from a registered-read memory, with a write forward, so the send pass need not wait on
// the read. Reset clears all control state at once; the queue memory needs no clearing pass.
module keyboard_scancode_translator_core import kst_pkg::*; #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  kst_stream_if.sink    cfg_i,
  kst_stream_if.sink    in_i,
  kst_stream_if.source  out_o
);

  // configuration: loaded into the lock bits by a start sequence
  logic [2:0] init_leds_q;
  cfg_item_t  cfg_item;

  assign cfg_i.ready = 1'b1;
  assign cfg_item    = cfg_i.payload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_leds_q <= '0;
    end else if (cfg_i.valid) begin
      init_leds_q <= cfg_item.initial_leds;
    end
  end

  // translator state: shift keys, lock bits, byte waiting for acknowledge
  logic [1:0] shift_q, shift_d;
  logic [2:0] lock_q, lock_d;
  logic       pv_q, pv_d;
  logic [7:0] pb_q, pb_d;

  in_item_t   in_item;
  logic       in_fire, space;
  logic       is_start, is_scan;
  logic       send, pv_mid, sh_held, caps, letter;
  logic [7:0] pb_mid, sc, ch_raw, ch;
  logic       act_vld;
  logic [1:0] act_code;
  logic       sec_vld;
  out_item_t  sec, res0, res1;
  logic [1:0] wr_cnt;
  q_cmd_t     q_cmd;
  q_stat_t    q_stat;

  assign in_item    = in_i.payload;
  assign in_i.ready = space;
  assign in_fire    = in_i.valid && space;
  assign sc         = in_item.scancode;
  assign is_start   = in_item.op == OP_START;
  assign is_scan    = in_item.op == OP_SCAN;

  // send pass: oldest queued byte goes out when nothing awaits acknowledge and the item is not a start
  assign send   = !is_start && q_stat.nonempty && !pv_q;
  assign pv_mid = pv_q || send;
  assign pb_mid = send ? q_stat.head_byte : pb_q;

  // character lookup; caps lock flips letter case, shift flips it back
  assign sh_held = shift_q != 2'b00;
  assign caps    = lock_q[LOCK_CAPS];
  assign ch_raw  = sc[7] ? 8'h00 : (sh_held ? TBL_SHIFT[sc[6:0]] : TBL_PLAIN[sc[6:0]]);
  assign letter  = ch_raw inside {[8'h41:8'h5a]};
  assign ch      = (letter && (caps == sh_held)) ? ch_raw + CASE_FLIP : ch_raw;

  always_comb begin
    act_vld  = 1'b1;
    act_code = ACT_TAB;
    if (sc == SC_TAB) begin
      act_code = ACT_TAB;
    end else if (sc == SC_F1 && sh_held) begin
      act_code = ACT_BREAK;
    end else if (sc == SC_F2 && sh_held) begin
      act_code = ACT_NEWCON;
    end else if (sc == SC_F11) begin
      act_code = ACT_RAISE;
    end else begin
      act_vld = 1'b0;
    end
  end

  // second result: character, window action or resend are mutually exclusive
  always_comb begin
    sec_vld   = 1'b0;
    sec.kind  = KIND_CHAR;
    sec.value = ch;
    sec.last  = 1'b1;
    if (is_scan) begin
      if (ch != 8'h00) begin
        sec_vld = 1'b1;
      end else if (act_vld) begin
        sec_vld   = 1'b1;
        sec.kind  = KIND_ACTION;
        sec.value = {6'b0, act_code};
      end else if (sc == SC_RESEND && pv_mid) begin
        sec_vld   = 1'b1;
        sec.kind  = KIND_SEND;
        sec.value = pb_mid;
      end
    end
  end

  always_comb begin
    res1 = sec;
    if (send) begin
      res0.kind  = KIND_SEND;
      res0.value = pb_mid;
      res0.last  = !sec_vld;
    end else begin
      res0 = sec;
    end
    wr_cnt = in_fire ? ({1'b0, send} + {1'b0, sec_vld}) : 2'd0;
  end

  // state update and queue commands
  always_comb begin
    shift_d     = shift_q;
    lock_d      = lock_q;
    pv_d        = pv_q;
    pb_d        = pb_q;
    q_cmd.clear = 1'b0;
    q_cmd.pop   = 1'b0;
    q_cmd.push  = 1'b0;
    if (in_fire) begin
      if (is_start) begin
        shift_d     = 2'b00;
        lock_d      = init_leds_q;
        pv_d        = 1'b0;
        pb_d        = 8'h00;
        q_cmd.clear = 1'b1;
        q_cmd.push  = 1'b1;
      end else begin
        pv_d      = pv_mid;
        pb_d      = pb_mid;
        q_cmd.pop = send;
        if (is_scan) begin
          case (sc)
            SC_LSHIFT_MAKE: shift_d = shift_q | 2'b01;
            SC_RSHIFT_MAKE: shift_d = shift_q | 2'b10;
            SC_LSHIFT_BRK:  shift_d = shift_q & 2'b10;
            SC_RSHIFT_BRK:  shift_d = shift_q & 2'b01;
            SC_CAPS: begin
              lock_d     = lock_q ^ (3'b1 << LOCK_CAPS);
              q_cmd.push = 1'b1;
            end
            SC_NUM: begin
              lock_d     = lock_q ^ (3'b1 << LOCK_NUM);
              q_cmd.push = 1'b1;
            end
            SC_SCROLL: begin
              lock_d     = lock_q ^ (3'b1 << LOCK_SCROLL);
              q_cmd.push = 1'b1;
            end
            SC_ACK:  pv_d = 1'b0;
            default: ;
          endcase
        end
      end
    end
    q_cmd.lock = lock_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      lock_q  <= '0;
      pv_q    <= 1'b0;
      pb_q    <= '0;
    end else begin
      shift_q <= shift_d;
      lock_q  <= lock_d;
      pv_q    <= pv_d;
      pb_q    <= pb_d;
    end
  end

  kst_cmd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (q_cmd),
    .stat_o (q_stat)
  );

  out_item_t out_data;
  logic      out_valid;

  kst_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_cnt_i (wr_cnt),
    .wr0_i    (res0),
    .wr1_i    (res1),
    .space_o  (space),
    .valid_o  (out_valid),
    .data_o   (out_data),
    .ready_i  (out_o.ready)
  );

  assign out_o.valid   = out_valid;
  assign out_o.payload = out_data;

  // an acknowledge in the same transfer clears the byte just sent
  a_send_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && send && !(is_scan && sc == SC_ACK) |=> pv_q)
    else $error("sent byte not marked pending");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_start |-> wr_cnt == 2'd0 ##1 (shift_q == 2'b00 && !pv_q))
    else $error("start sequence left state behind");

  a_ack_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_scan && sc == SC_ACK |=> !pv_q)
    else $error("acknowledge did not clear pending byte");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import kst_pkg::*;

  localparam int QDEPTH      = 32;
  localparam int CYCLE_LIMIT = 400000;
  // Results leave a small buffer one per cycle while the monitor is ready; SETTLE adds
  // slack to cover anything still in flight behind an item that produced no result.
  localparam int SETTLE      = 8;

  logic clk_i;
  logic rst_ni;

  kst_stream_if #(.payload_t(cfg_item_t)) cfg_if ();
  kst_stream_if #(.payload_t(in_item_t))  in_if ();
  kst_stream_if #(.payload_t(out_item_t)) out_if ();

  keyboard_scancode_translator_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Translator state as the testbench tracks it
  // ---------------------------------------------------------------------------
  byte unsigned key_plain [128];
  byte unsigned key_shifted [128];

  logic [2:0]  leds_cfg;      // register copy, loaded into lock_state on start
  logic [1:0]  shift_held;    // bit0 left, bit1 right
  logic [2:0]  lock_state;    // caps, num, scroll
  logic        ack_wait;      // a byte went out and no 0xFA yet
  logic [7:0]  wait_byte;
  logic [7:0]  led_cmds [$];  // bytes still to go to the keyboard

  in_item_t    stim_q [$];    // items not yet offered to the block
  out_item_t   awaited_q [$]; // results predicted but not yet seen

  int gap_pct;
  int stall_pct;
  int items_queued;
  int items_taken;
  int results_seen;
  int starts_taken;
  int err_cnt;
  int cycles;

  out_item_t got;
  out_item_t want;

  task automatic set_keys(input int first, input string plain, input string shifted);
    for (int i = 0; i < plain.len(); i++) begin
      key_plain[first + i]   = plain[i];
      key_shifted[first + i] = shifted[i];
    end
  endtask

  // Bytes past the queue depth are dropped, as the block does.
  function automatic void push_cmd(input logic [7:0] b);
    if (led_cmds.size() < QDEPTH) begin
      led_cmds.push_back(b);
    end
  endfunction

  function automatic void queue_led_update();
    push_cmd(LED_CMD);
    push_cmd({5'd0, lock_state});
  endfunction

  // Work out the results of one accepted item and append them to awaited_q.
  function automatic void translate_item(input in_item_t it);
    out_item_t   res [$];
    logic [7:0]  ch;
    logic [7:0]  sc;
    logic        shifted;

    sc = it.scancode;
    if (it.op == OP_START) begin
      shift_held = '0;
      ack_wait   = 1'b0;
      wait_byte  = '0;
      led_cmds.delete();
      lock_state = leds_cfg;
      queue_led_update();
      starts_taken++;
      return;
    end

    // Send pass comes before anything the scan code does.
    if (led_cmds.size() != 0 && !ack_wait) begin
      wait_byte = led_cmds.pop_front();
      ack_wait  = 1'b1;
      res.push_back(out_item_t'{kind: KIND_SEND, value: wait_byte, last: 1'b0});
    end

    if (it.op == OP_SCAN) begin
      shifted = (shift_held != 2'b00);
      ch = '0;
      if (!sc[7]) begin
        ch = shifted ? key_shifted[sc[6:0]] : key_plain[sc[6:0]];
      end
      // Letters come out lower case unless exactly one of caps / shift is on.
      if (ch >= "A" && ch <= "Z" && (lock_state[LOCK_CAPS] == shifted)) begin
        ch = ch + CASE_FLIP;
      end
      if (ch != 8'd0) begin
        res.push_back(out_item_t'{kind: KIND_CHAR, value: ch, last: 1'b0});
      end

      if (sc == SC_TAB) begin
        res.push_back(out_item_t'{kind: KIND_ACTION, value: {6'd0, ACT_TAB}, last: 1'b0});
      end else if (sc == SC_F1 && shifted) begin
        res.push_back(out_item_t'{kind: KIND_ACTION, value: {6'd0, ACT_BREAK}, last: 1'b0});
      end else if (sc == SC_F2 && shifted) begin
        res.push_back(out_item_t'{kind: KIND_ACTION, value: {6'd0, ACT_NEWCON}, last: 1'b0});
      end else if (sc == SC_F11) begin
        res.push_back(out_item_t'{kind: KIND_ACTION, value: {6'd0, ACT_RAISE}, last: 1'b0});
      end

      case (sc)
        SC_LSHIFT_MAKE: shift_held[0] = 1'b1;
        SC_RSHIFT_MAKE: shift_held[1] = 1'b1;
        SC_LSHIFT_BRK:  shift_held[0] = 1'b0;
        SC_RSHIFT_BRK:  shift_held[1] = 1'b0;
        SC_CAPS: begin
          lock_state[LOCK_CAPS] = ~lock_state[LOCK_CAPS];
          queue_led_update();
        end
        SC_NUM: begin
          lock_state[LOCK_NUM] = ~lock_state[LOCK_NUM];
          queue_led_update();
        end
        SC_SCROLL: begin
          lock_state[LOCK_SCROLL] = ~lock_state[LOCK_SCROLL];
          queue_led_update();
        end
        SC_ACK: ack_wait = 1'b0;
        SC_RESEND: begin
          // Only a byte still awaiting its acknowledge is sent again.
          if (ack_wait) begin
            res.push_back(out_item_t'{kind: KIND_SEND, value: wait_byte, last: 1'b0});
          end
        end
        default: ;
      endcase
    end

    if (res.size() != 0) begin
      res[res.size() - 1].last = 1'b1;
    end
    foreach (res[i]) begin
      awaited_q.push_back(res[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the next pending item, with random gaps; predicts on
  // every transfer so prediction follows acceptance order exactly.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        translate_item(in_if.payload);
        items_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (stim_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          in_if.valid   <= 1'b1;
          in_if.payload <= stim_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, each result checked against the oldest
  // prediction field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        results_seen++;
        if (awaited_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected: kind %0d value %02h last %0b",
                   $time, got.kind, got.value, got.last);
        end else begin
          want = awaited_q.pop_front();
          if (got.kind !== want.kind) begin
            err_cnt++;
            $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
          end
          if (got.value !== want.value) begin
            err_cnt++;
            $display("%0t: value expected %02h got %02h", $time, want.value, got.value);
          end
          if (got.last !== want.last) begin
            err_cnt++;
            $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still awaited", $time, awaited_q.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_item(input logic [1:0] op, input logic [7:0] sc);
    stim_q.push_back(in_item_t'{op: op, scancode: sc});
    items_queued++;
  endtask

  // Block is idle once every queued item went in and every result came out.
  task automatic wait_idle();
    while (items_taken != items_queued || awaited_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Called at a clock edge; returns at the edge of the transfer.
  task automatic write_leds(input logic [2:0] v);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= cfg_item_t'{initial_leds: v};
    do @(posedge clk_i); while (!cfg_if.ready);
    leds_cfg = v;
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly what a keyboard and its driver would produce: key make/break
  // pairs, shift held across keys, lock toggles and the keyboard's
  // acknowledges for LED bytes. The rest is resends, restarts, full-queue
  // bursts of lock keys and raw noise.
  task automatic gen_traffic(input int n);
    int          stop_at;
    int          r;
    logic [7:0]  code;
    logic [7:0]  locks [3];

    locks[0] = SC_CAPS;
    locks[1] = SC_NUM;
    locks[2] = SC_SCROLL;
    stop_at = items_queued + n;
    add_item(OP_START, 8'($urandom));
    while (items_queued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 32) begin
        code = 8'($urandom_range(0, 127));
        add_item(OP_SCAN, code);
        if ($urandom_range(0, 1) == 1) begin
          add_item(OP_SCAN, code | 8'h80);
        end
      end else if (r < 42) begin
        case ($urandom_range(0, 3))
          0: add_item(OP_SCAN, SC_LSHIFT_MAKE);
          1: add_item(OP_SCAN, SC_RSHIFT_MAKE);
          2: add_item(OP_SCAN, SC_LSHIFT_BRK);
          default: add_item(OP_SCAN, SC_RSHIFT_BRK);
        endcase
      end else if (r < 50) begin
        add_item(OP_SCAN, locks[$urandom_range(0, 2)]);
      end else if (r < 62) begin
        add_item(($urandom_range(0, 4) == 0) ? 2'd3 : OP_IDLE, 8'($urandom));
      end else if (r < 80) begin
        add_item(OP_SCAN, SC_ACK);
      end else if (r < 85) begin
        add_item(OP_SCAN, SC_RESEND);
      end else if (r < 87) begin
        add_item(OP_START, 8'($urandom));
      end else if (r < 88) begin
        // enough toggles to overflow the command queue
        repeat ($urandom_range(17, 20)) add_item(OP_SCAN, locks[$urandom_range(0, 2)]);
      end else begin
        add_item(2'($urandom), 8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          idle_mix [4];
    int          stall_mix [4];
    logic [2:0]  led_mix [4];

    rst_ni         = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    gap_pct        = 0;
    stall_pct      = 0;
    items_queued   = 0;
    items_taken    = 0;
    results_seen   = 0;
    starts_taken   = 0;
    err_cnt        = 0;
    cycles         = 0;
    leds_cfg       = '0;
    shift_held     = '0;
    lock_state     = '0;
    ack_wait       = 1'b0;
    wait_byte      = '0;

    // Set-1 layout, plain and shifted.
    foreach (key_plain[i]) begin
      key_plain[i]   = 8'd0;
      key_shifted[i] = 8'd0;
    end
    set_keys('h02, "1234567890-^", "!\"#$%&'()~=~");
    set_keys('h10, "QWERTYUIOP@[", "QWERTYUIOP`{");
    set_keys('h1e, "ASDFGHJKL;:", "ASDFGHJKL+*");
    set_keys('h2b, "]ZXCVBNM,./", "}ZXCVBNM<>?");
    set_keys('h37, "*", "*");
    set_keys('h39, " ", " ");
    set_keys('h47, "789-456+1230.", "789-456+1230.");
    set_keys('h73, "\\", "_");
    set_keys('h7d, "\\", "|");
    key_plain['h0e]   = 8'h08;
    key_shifted['h0e] = 8'h08;
    key_plain['h1c]   = 8'h0a;
    key_shifted['h1c] = 8'h0a;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: LED handshake corner cases first, then keys at the edges.
    write_leds(3'b101);
    add_item(OP_START,  8'h00);
    add_item(OP_IDLE,   8'hff);            // 0xED goes out
    add_item(OP_SCAN,   SC_ACK);
    add_item(OP_SCAN,   SC_RESEND);        // lock byte sent and resent together
    add_item(OP_SCAN,   SC_ACK);
    add_item(OP_SCAN,   SC_ACK);           // acknowledge with nothing pending
    add_item(OP_SCAN,   SC_RESEND);        // resend with nothing pending
    add_item(2'd3,      8'hff);            // unused op behaves as idle
    add_item(OP_SCAN,   SC_CAPS);
    add_item(OP_SCAN,   SC_ACK);           // send and acknowledge in one step
    add_item(OP_SCAN,   8'h10);
    add_item(OP_SCAN,   SC_LSHIFT_MAKE);
    add_item(OP_SCAN,   8'h10);
    add_item(OP_SCAN,   SC_F1);
    add_item(OP_SCAN,   SC_F2);
    add_item(OP_SCAN,   8'h0b);
    add_item(OP_SCAN,   SC_RSHIFT_MAKE);
    add_item(OP_SCAN,   SC_LSHIFT_BRK);    // right shift still held
    add_item(OP_SCAN,   8'h02);
    add_item(OP_SCAN,   SC_RSHIFT_BRK);
    add_item(OP_SCAN,   8'h00);
    add_item(OP_SCAN,   8'h7f);
    add_item(OP_SCAN,   8'h80);
    add_item(OP_SCAN,   8'hff);
    add_item(OP_SCAN,   SC_TAB);
    add_item(OP_SCAN,   SC_F11);
    add_item(OP_SCAN,   SC_NUM);
    add_item(OP_SCAN,   SC_SCROLL);
    wait_idle();

    // Random phases: free flow, slow sender, slow receiver, both.
    idle_mix  = '{0, 60, 0, 16};
    stall_mix = '{0, 0, 60, 16};
    led_mix   = '{3'b000, 3'b111, 3'b010, 3'($urandom)};
    for (int p = 0; p < 4; p++) begin
      write_leds(led_mix[p]);
      gap_pct   = idle_mix[p];
      stall_pct = stall_mix[p];
      gen_traffic(270);
      wait_idle();
    end

    $display("%0d items in (%0d starts), %0d results checked over 5 phases,",
             items_taken, starts_taken, results_seen);
    $display("LED settings from 000 to 111 with and without back-pressure");
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
